FILE: rtl/multi_channel_linear_ramp_smoother_defines.svh
// Assertion helpers for the ramp smoother checker.
// Both expect clk and rst in the scope where they are used.
`ifndef MULTI_CHANNEL_LINEAR_RAMP_SMOOTHER_DEFINES_SVH
`define MULTI_CHANNEL_LINEAR_RAMP_SMOOTHER_DEFINES_SVH

// Same-cycle implication.
`define MCRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mcrs_pkg.sv
`default_nettype none
package mcrs_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MAX_OUT          = 8;
  localparam int VALUE_W          = 32;
  localparam int SAMPLES_W        = 20;
  localparam int CH_W             = 3;
  localparam int DIVIDEND_W       = VALUE_W + 1;

  localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 20'd2400;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_INIT = 2'd2,
    OP_SNAP = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] start;
    logic [VALUE_W-1:0] target;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/mcrs_front.sv
`default_nettype none
module mcrs_front #(
  parameter int NUM_CHANNELS = mcrs_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [1:0]                         op,
  input  wire logic [mcrs_pkg::CH_W-1:0]          channel,
  input  wire logic signed [mcrs_pkg::VALUE_W-1:0] start_value,
  input  wire logic signed [mcrs_pkg::VALUE_W-1:0] target_value,
  output mcrs_pkg::cmd_t                          cmd,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_ready
);

  localparam logic [6:0] NUM_LIM = 7'(NUM_CHANNELS);

  mcrs_pkg::cmd_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  mcrs_pkg::op_t  op_in;
  logic           addressed;
  logic           in_range;
  logic           wr;
  logic           rd;

  // Set target and init on a channel that does not exist are dropped here.
  assign op_in     = mcrs_pkg::op_t'(op);
  assign addressed = (op_in == mcrs_pkg::OP_SET) || (op_in == mcrs_pkg::OP_INIT);
  assign in_range  = {4'b0000, channel} < NUM_LIM;
  assign full      = (cnt == 2'd2);
  assign wr        = push && !full && !(addressed && !in_range);
  assign cmd_valid = (cnt != 2'd0);
  assign rd        = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp].op     <= op_in;
      q[wp].ch     <= channel;
      q[wp].start  <= start_value;
      q[wp].target <= target_value;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mcrs_div.sv
`default_nettype none
module mcrs_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                go,
  input  wire logic [mcrs_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire logic [mcrs_pkg::SAMPLES_W-1:0]      divisor,
  output logic                                     done,
  output logic [mcrs_pkg::DIVIDEND_W-1:0]          quotient
);

  localparam int DW = mcrs_pkg::DIVIDEND_W;
  localparam int SW = mcrs_pkg::SAMPLES_W;

  logic          busy;
  logic [5:0]    cnt;
  logic [SW-1:0] rem;
  logic [SW-1:0] dv;
  logic [DW-1:0] quo;
  logic [SW:0]   sh;
  logic [SW:0]   sub;
  logic          ge;
  logic [SW-1:0] rem_next;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign sh       = {rem, quo[DW-1]};
  assign sub      = sh - {1'b0, dv};
  assign ge       = sh >= {1'b0, dv};
  assign rem_next = ge ? sub[SW-1:0] : sh[SW-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mcrs_back.sv
`default_nettype none
module mcrs_back #(
  parameter int NUM_CHANNELS = mcrs_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mcrs_pkg::cmd_t                     cmd,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_ready,
  input  wire logic [mcrs_pkg::SAMPLES_W-1:0]     samples,
  input  wire logic                               pop,
  output logic                                    empty,
  output logic [mcrs_pkg::CH_W-1:0]               out_channel,
  output logic signed [mcrs_pkg::VALUE_W-1:0]     smoothed_value,
  output logic                                    channel_changing,
  output logic                                    any_changing,
  output logic                                    last_result
);

  localparam int VW    = mcrs_pkg::VALUE_W;
  localparam int DW    = mcrs_pkg::DIVIDEND_W;
  // Channels above the reachable range never ramp, so they need no storage.
  localparam int NCH   = (NUM_CHANNELS < mcrs_pkg::MAX_OUT) ? NUM_CHANNELS
                                                            : mcrs_pkg::MAX_OUT;
  localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCH - 1);
  localparam logic [DW-1:0] POS_MAX = {2'b00, {(VW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MAG = {2'b01, {(VW-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD   = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_DIFF   = 9'b000001000,
    S_SETUP  = 9'b000010000,
    S_DIVIDE = 9'b000100000,
    S_REPLY  = 9'b001000000,
    S_UPDATE = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t         state;
  logic [VW-1:0]  cur [NCH];
  logic [VW-1:0]  tgt [NCH];
  logic [VW-1:0]  inc [NCH];
  logic [NCH-1:0] ramp;

  logic [IDX_W-1:0] idx;
  mcrs_pkg::op_t    op_r;
  logic [VW-1:0]    start_r;
  logic [VW-1:0]    target_r;
  logic [DW-1:0]    diff_r;
  logic             neg_r;
  logic             out_valid;

  logic [VW-1:0]   cur_rd;
  logic [VW-1:0]   tgt_rd;
  logic [VW-1:0]   inc_rd;
  logic            ramp_rd;
  logic            any_ramp;
  logic            slot_free;
  logic [DW-1:0]   nx;
  logic            reached;
  logic [DW-1:0]   diff_w;
  logic [DW-1:0]   mag;
  logic [mcrs_pkg::SAMPLES_W-1:0] len;
  logic            div_go;
  logic            div_done;
  logic [DW-1:0]   quo;
  logic [DW-1:0]   quo_neg;
  logic [VW-1:0]   inc_fin;

  assign cur_rd    = cur[idx];
  assign tgt_rd    = tgt[idx];
  assign inc_rd    = inc[idx];
  assign ramp_rd   = ramp[idx];
  assign any_ramp  = |ramp;
  assign cmd_ready = (state == S_IDLE);
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;

  // Tick: step and clamp at the target in the step's direction.
  assign nx      = {cur_rd[VW-1], cur_rd} + {inc_rd[VW-1], inc_rd};
  assign reached = inc_rd[VW-1] ? ($signed(nx) <= $signed({tgt_rd[VW-1], tgt_rd}))
                                : ($signed(nx) >= $signed({tgt_rd[VW-1], tgt_rd}));

  // New ramp: magnitude of the distance over the ramp length.
  assign diff_w = {target_r[VW-1], target_r} - {cur_rd[VW-1], cur_rd};
  assign mag    = neg_r ? (~diff_r + 1'b1) : diff_r;
  assign len    = (samples == '0) ? mcrs_pkg::SAMPLES_RESET : samples;
  assign div_go = (state == S_SETUP) && (diff_r != '0);

  mcrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (mag),
    .divisor  (len),
    .done     (div_done),
    .quotient (quo)
  );

  // Sign back, force one LSB on a zero step, saturate to 32 bits.
  assign quo_neg = ~quo + 1'b1;
  always_comb begin
    if (quo == '0) begin
      inc_fin = neg_r ? {VW{1'b1}} : VW'(1);
    end else if (!neg_r) begin
      inc_fin = (quo > POS_MAX) ? POS_MAX[VW-1:0] : quo[VW-1:0];
    end else begin
      inc_fin = (quo > NEG_MAG) ? NEG_MAG[VW-1:0] : quo_neg[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      ramp      <= '0;
      for (int c = 0; c < NCH; c++) begin
        cur[c] <= '0;
        tgt[c] <= '0;
        inc[c] <= '0;
      end
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_r     <= cmd.op;
            start_r  <= cmd.start;
            target_r <= cmd.target;
            unique case (cmd.op)
              mcrs_pkg::OP_TICK, mcrs_pkg::OP_SNAP: begin
                idx   <= '0;
                state <= S_UPDATE;
              end
              mcrs_pkg::OP_INIT: begin
                idx   <= cmd.ch[IDX_W-1:0];
                state <= S_LOAD;
              end
              mcrs_pkg::OP_SET: begin
                idx   <= cmd.ch[IDX_W-1:0];
                state <= S_CHECK;
              end
            endcase
          end
        end
        S_LOAD: begin
          cur[idx] <= start_r;
          state    <= S_DIFF;
        end
        S_CHECK: begin
          state <= (target_r == tgt_rd) ? S_REPLY : S_DIFF;
        end
        S_DIFF: begin
          diff_r <= diff_w;
          neg_r  <= diff_w[DW-1];
          state  <= S_SETUP;
        end
        S_SETUP: begin
          if (diff_r == '0) begin
            tgt[idx]  <= target_r;
            inc[idx]  <= '0;
            ramp[idx] <= 1'b0;
            state     <= S_REPLY;
          end else begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            tgt[idx]  <= target_r;
            inc[idx]  <= inc_fin;
            ramp[idx] <= 1'b1;
            state     <= S_REPLY;
          end
        end
        S_REPLY: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_channel      <= 3'(idx);
            smoothed_value   <= tgt_rd;
            channel_changing <= ramp_rd;
            any_changing     <= any_ramp;
            last_result      <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_UPDATE: begin
          if (op_r == mcrs_pkg::OP_SNAP) begin
            cur[idx]  <= tgt_rd;
            inc[idx]  <= '0;
            ramp[idx] <= 1'b0;
          end else if (ramp_rd) begin
            if (reached) begin
              cur[idx]  <= tgt_rd;
              inc[idx]  <= '0;
              ramp[idx] <= 1'b0;
            end else begin
              cur[idx] <= nx[VW-1:0];
            end
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          // A channel at rest holds its target, so cur is the value to show.
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_channel      <= 3'(idx);
            smoothed_value   <= cur_rd;
            channel_changing <= ramp_rd;
            any_changing     <= any_ramp;
            last_result      <= (idx == LAST_IDX);
            if (idx == LAST_IDX) begin
              idx   <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multi_channel_linear_ramp_smoother.sv
// Sequencing: a tick or snap runs an update pass over every channel (NCH = channels up to 8), then
//   an emit pass with one result per cycle while pop keeps the result slot free; a set or init
//   that starts a new ramp waits on the 33-step divider, while one that starts none skips it.
// Reset (rst, synchronous, active high): all channels at zero and at rest, queues
//   empty, transition_samples back to 2400.
`default_nettype none
module multi_channel_linear_ramp_smoother #(
  parameter int NUM_CHANNELS = mcrs_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // command side
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [1:0]                          op,
  input  wire logic [mcrs_pkg::CH_W-1:0]           channel,
  input  wire logic signed [mcrs_pkg::VALUE_W-1:0] start_value,
  input  wire logic signed [mcrs_pkg::VALUE_W-1:0] target_value,
  // result side
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [mcrs_pkg::CH_W-1:0]                out_channel,
  output logic signed [mcrs_pkg::VALUE_W-1:0]      smoothed_value,
  output logic                                     channel_changing,
  output logic                                     any_changing,
  output logic                                     last_result,
  // ramp length register
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mcrs_pkg::SAMPLES_W-1:0]      cfg_data
);

  mcrs_pkg::cmd_t                  cmd;
  logic                            cmd_valid;
  logic                            cmd_ready;
  logic [mcrs_pkg::SAMPLES_W-1:0]  transition_samples;

  // Register transfers are always taken; software writes only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_samples <= mcrs_pkg::SAMPLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      transition_samples <= cfg_data;
    end
  end

  // Front: takes pushes, drops out-of-range channel ops, queues the rest.
  mcrs_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .channel      (channel),
    .start_value  (start_value),
    .target_value (target_value),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready)
  );

  // Back: channel state, sequencer, divider and the result register.
  mcrs_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .samples          (transition_samples),
    .pop              (pop),
    .empty            (empty),
    .out_channel      (out_channel),
    .smoothed_value   (smoothed_value),
    .channel_changing (channel_changing),
    .any_changing     (any_changing),
    .last_result      (last_result)
  );

endmodule
`default_nettype wire

FILE: rtl/mcrs_checker.sv
`default_nettype none
`include "multi_channel_linear_ramp_smoother_defines.svh"
module mcrs_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                pop,
  input wire logic                                empty,
  input wire logic [mcrs_pkg::CH_W-1:0]           out_channel,
  input wire logic signed [mcrs_pkg::VALUE_W-1:0] smoothed_value,
  input wire logic                                channel_changing,
  input wire logic                                any_changing,
  input wire logic                                last_result
);

  `MCRS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(smoothed_value) && $stable(out_channel), "result changed while stalled")

  `MCRS_ASSERT_NOW(a_any, !empty && channel_changing, any_changing, "channel ramping but any_changing low")

  `MCRS_ASSERT_NOW(a_last, !empty && !last_result, out_channel != 3'd7, "channel 7 result not marked last")

  `MCRS_ASSERT_NEXT(a_order, !empty && pop && !last_result, empty || (out_channel == $past(out_channel) + 3'd1), "tick results out of channel order")

endmodule

bind multi_channel_linear_ramp_smoother mcrs_checker u_mcrs_checker (.*);
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int NCH = mcrs_pkg::NUM_CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // Margin after the last expected result is taken, before a register
  // write and before the final verdict.
  localparam int SETTLE_CYCLES = 60;
  localparam int NO_CFG = -1;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int SAMPLES_MAX = 1048575;
  localparam int DEFAULT_LEN = 2400;
  localparam longint STEP_MAX = 64'sd2147483647;
  localparam longint STEP_MIN = -64'sd2147483648;
  localparam logic [mcrs_pkg::VALUE_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [mcrs_pkg::VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [mcrs_pkg::VALUE_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                push = 1'b0;
  logic                                full;
  logic [1:0]                          op = mcrs_pkg::OP_TICK;
  logic [mcrs_pkg::CH_W-1:0]           channel = '0;
  logic signed [mcrs_pkg::VALUE_W-1:0] start_value = '0;
  logic signed [mcrs_pkg::VALUE_W-1:0] target_value = '0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic [mcrs_pkg::CH_W-1:0]           out_channel;
  logic signed [mcrs_pkg::VALUE_W-1:0] smoothed_value;
  logic                                channel_changing;
  logic                                any_changing;
  logic                                last_result;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [mcrs_pkg::SAMPLES_W-1:0]      cfg_data = '0;

  multi_channel_linear_ramp_smoother uut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .op               (op),
    .channel          (channel),
    .start_value      (start_value),
    .target_value     (target_value),
    .empty            (empty),
    .pop              (pop),
    .out_channel      (out_channel),
    .smoothed_value   (smoothed_value),
    .channel_changing (channel_changing),
    .any_changing     (any_changing),
    .last_result      (last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Smoother shadow state
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [mcrs_pkg::CH_W-1:0]    ch;
    logic [mcrs_pkg::VALUE_W-1:0] value;
    logic                         chg;
    logic                         any;
    logic                         last;
  } ramp_output_t;

  ramp_output_t                   pending_outputs[$];
  longint                         cur_val[NCH];
  longint                         tgt_val[NCH];
  longint                         step_val[NCH];
  bit                             ramping[NCH];
  logic [mcrs_pkg::SAMPLES_W-1:0] ramp_len = mcrs_pkg::SAMPLES_RESET;

  int error_count = 0;
  int cycle_count = 0;
  int feed_idle_pct = 0;   // % of cycles the command side holds off
  int drain_idle_pct = 0;  // % of cycles the result side holds off

  initial begin
    for (int c = 0; c < NCH; c++) begin
      cur_val[c] = 0;
      tgt_val[c] = 0;
      step_val[c] = 0;
      ramping[c] = 1'b0;
    end
  end

  // Store a new target and work out the per-sample step toward it.
  function automatic void begin_ramp(int c, longint tgt);
    longint diff;
    longint len;
    longint inc;
    diff = tgt - cur_val[c];
    len = (ramp_len == 0) ? longint'(DEFAULT_LEN) : longint'(ramp_len);
    tgt_val[c] = tgt;
    if (diff == 0) begin
      // already there: park the channel
      step_val[c] = 0;
      ramping[c] = 1'b0;
      return;
    end
    inc = diff / len;  // truncates toward zero
    if (inc == 0)
      inc = (diff > 0) ? 1 : -1;  // never stall on a tiny difference
    if (inc > STEP_MAX)
      inc = STEP_MAX;
    if (inc < STEP_MIN)
      inc = STEP_MIN;
    step_val[c] = inc;
    ramping[c] = 1'b1;
  endfunction

  function automatic bit any_ramping();
    for (int c = 0; c < NCH; c++)
      if (ramping[c])
        return 1'b1;
    return 1'b0;
  endfunction

  // Advance the shadow state by one accepted command and queue what the
  // block owes us. A typed row overrides value and channel_changing with
  // numbers written straight into the stimulus table.
  task automatic apply_command(input mcrs_pkg::op_t cmd, input int ch,
                               input logic [mcrs_pkg::VALUE_W-1:0] start,
                               input logic [mcrs_pkg::VALUE_W-1:0] tgt, input bit typed,
                               input logic [mcrs_pkg::VALUE_W-1:0] typed_val,
                               input bit typed_chg);
    ramp_output_t r;
    longint       vals[NCH];
    longint       nx;
    longint       tgt_l;
    bit           done;
    bit           any;
    tgt_l = longint'(signed'(tgt));
    if (cmd == mcrs_pkg::OP_SET || cmd == mcrs_pkg::OP_INIT) begin
      if (cmd == mcrs_pkg::OP_INIT) begin
        cur_val[ch] = longint'(signed'(start));
        begin_ramp(ch, tgt_l);
      end else if (tgt_l != tgt_val[ch]) begin
        begin_ramp(ch, tgt_l);
      end
      r.ch = ch[mcrs_pkg::CH_W-1:0];
      r.value = 32'(tgt_val[ch]);
      r.chg = ramping[ch];
      r.any = any_ramping();
      r.last = 1'b1;
      if (typed) begin
        r.value = typed_val;
        r.chg = typed_chg;
      end
      pending_outputs.push_back(r);
    end else begin
      for (int c = 0; c < NCH; c++) begin
        if (cmd == mcrs_pkg::OP_SNAP) begin
          if (ramping[c]) begin
            cur_val[c] = tgt_val[c];
            ramping[c] = 1'b0;
            step_val[c] = 0;
          end
          vals[c] = tgt_val[c];
        end else if (ramping[c]) begin
          nx = cur_val[c] + step_val[c];
          done = (step_val[c] > 0) ? (nx >= tgt_val[c]) : (nx <= tgt_val[c]);
          if (done) begin
            // clamp on arrival
            nx = tgt_val[c];
            step_val[c] = 0;
            ramping[c] = 1'b0;
          end
          cur_val[c] = nx;
          vals[c] = nx;
        end else begin
          vals[c] = tgt_val[c];
        end
      end
      any = any_ramping();
      for (int c = 0; c < NCH; c++) begin
        r.ch = c[mcrs_pkg::CH_W-1:0];
        r.value = 32'(vals[c]);
        r.chg = ramping[c];
        r.any = any;
        r.last = (c == NCH - 1);
        if (typed) begin
          r.value = typed_val;
          r.chg = typed_chg;
        end
        pending_outputs.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Push stays high between back-to-back commands; it only drops during a
  // random hold-off or a drain, so it never sees two assignments in one step.
  task automatic send_command(input mcrs_pkg::op_t cmd, input int ch,
                              input logic [mcrs_pkg::VALUE_W-1:0] start,
                              input logic [mcrs_pkg::VALUE_W-1:0] tgt, input bit typed,
                              input logic [mcrs_pkg::VALUE_W-1:0] typed_val,
                              input bit typed_chg);
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= cmd;
    channel <= ch[mcrs_pkg::CH_W-1:0];
    start_value <= start;
    target_value <= tgt;
    do
      @(posedge clk);
    while (full !== 1'b0);
    apply_command(cmd, ch, start, tgt, typed, typed_val, typed_chg);
  endtask

  task automatic drain_outputs();
    push <= 1'b0;
    while (pending_outputs.size() != 0)
      @(posedge clk);
  endtask

  // Ramp length may only change with the block at rest.
  task automatic write_ramp_length(input int len);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len[mcrs_pkg::SAMPLES_W-1:0];
    do
      @(posedge clk);
    while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ramp_len = len[mcrs_pkg::SAMPLES_W-1:0];
  endtask

  // Mix of targets: rails, steps close to where the channel sits (so ramps
  // finish even when long), the stored target again, and plain noise.
  function automatic logic [mcrs_pkg::VALUE_W-1:0] pick_value(int ch);
    case ($urandom_range(19))
      0:             return Q_MIN;
      1:             return Q_MAX;
      2:             return '0;
      3:             return Q_NEG1;
      4, 5, 6, 7, 8: return 32'(cur_val[ch]) + $urandom_range(16) - 8;
      9, 10:         return 32'(tgt_val[ch]);
      default:       return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop, compare each transfer against the oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= ($urandom_range(99) >= drain_idle_pct);
  end

  task automatic check_field(input string name, input logic [mcrs_pkg::VALUE_W-1:0] want,
                             input logic [mcrs_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    ramp_output_t want;
    if (!rst && pop && empty === 1'b0) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected output, expected none, got ch %0d value %h",
                 $time, out_channel, smoothed_value);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("out_channel", 32'(want.ch), 32'(out_channel));
        check_field("smoothed_value", want.value, smoothed_value);
        check_field("channel_changing", 32'(want.chg), 32'(channel_changing));
        check_field("any_changing", 32'(want.any), 32'(any_changing));
        check_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    int                           len_before;  // ramp length written first, or NO_CFG
    mcrs_pkg::op_t                cmd;
    int                           ch;
    logic [mcrs_pkg::VALUE_W-1:0] start;
    logic [mcrs_pkg::VALUE_W-1:0] tgt;
    bit                           typed;
    logic [mcrs_pkg::VALUE_W-1:0] typed_val;
    bit                           typed_chg;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  directed_row_t directed_rows[DIRECTED_ROWS] = '{
    // out of reset everything sits at zero
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        1, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_SNAP, 0, '0,    '0,        1, '0,        0},
    // same target again is a no-op
    '{NO_CFG,      mcrs_pkg::OP_SET,  0, '0,    '0,        1, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_SET,  7, '0,    Q_MAX,     1, Q_MAX,     1},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    // init onto its own target: no ramp
    '{NO_CFG,      mcrs_pkg::OP_INIT, 3, Q_MIN, Q_MIN,     1, Q_MIN,     0},
    '{NO_CFG,      mcrs_pkg::OP_INIT, 3, Q_MIN, Q_MAX,     1, Q_MAX,     1},
    '{NO_CFG,      mcrs_pkg::OP_SET,  7, '0,    Q_MAX,     1, Q_MAX,     1},
    // small differences: step forced to one LSB either way
    '{NO_CFG,      mcrs_pkg::OP_INIT, 1, '0,    32'd100,   1, 32'd100,   1},
    '{NO_CFG,      mcrs_pkg::OP_INIT, 2, '0,    -32'sd100, 1, -32'sd100, 1},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    // ch1 has crept to 2: retarget onto the current value stops it
    '{NO_CFG,      mcrs_pkg::OP_SET,  1, '0,    32'd2,     1, 32'd2,     0},
    '{NO_CFG,      mcrs_pkg::OP_SNAP, 0, '0,    '0,        0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    // one-sample ramp across full scale saturates the step
    '{1,           mcrs_pkg::OP_INIT, 0, Q_MIN, Q_MAX,     1, Q_MAX,     1},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    // zero length falls back to the default
    '{0,           mcrs_pkg::OP_INIT, 5, '0,    32'd7200,  0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    '{SAMPLES_MAX, mcrs_pkg::OP_INIT, 4, Q_MAX, Q_MIN,     0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_SET,  6, '0,    Q_NEG1,    1, Q_NEG1,    1},
    '{NO_CFG,      mcrs_pkg::OP_TICK, 0, '0,    '0,        0, '0,        0},
    '{NO_CFG,      mcrs_pkg::OP_SNAP, 0, '0,    '0,        0, '0,        0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mcrs_pkg::op_t                cmd;
    int                           ch;
    int                           len;
    logic [mcrs_pkg::VALUE_W-1:0] sv;
    logic [mcrs_pkg::VALUE_W-1:0] tv;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // slow producer, very slow consumer
    feed_idle_pct = 37;
    drain_idle_pct = 83;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].len_before != NO_CFG)
        write_ramp_length(directed_rows[i].len_before);
      send_command(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].start,
                   directed_rows[i].tgt, directed_rows[i].typed, directed_rows[i].typed_val,
                   directed_rows[i].typed_chg);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // swap the pressure at phase 2, then run flat out from phase 4
      if (phase == 2) begin
        feed_idle_pct = 83;
        drain_idle_pct = 37;
      end else if (phase == 4) begin
        feed_idle_pct = 0;
        drain_idle_pct = 0;
      end

      case (phase)
        0:       len = 5;
        1:       len = SAMPLES_MAX;
        2:       len = 1;
        3:       len = 0;
        4:       len = $urandom_range(64, 2);
        default: len = $urandom_range(SAMPLES_MAX, 1);
      endcase
      write_ramp_length(len);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the block run dry once mid-stream
        if (phase == 1 && n == ITEMS_PER_PHASE / 2)
          drain_outputs();

        ch = $urandom_range(NCH - 1);
        sv = pick_value(ch);
        tv = pick_value(ch);
        case ($urandom_range(99)) inside
          [0:44]:  cmd = mcrs_pkg::OP_TICK;
          [45:69]: cmd = mcrs_pkg::OP_SET;
          [70:84]: cmd = mcrs_pkg::OP_INIT;
          default: cmd = mcrs_pkg::OP_SNAP;
        endcase
        if (cmd == mcrs_pkg::OP_INIT && $urandom_range(5) == 0)
          tv = sv;
        send_command(cmd, ch, sv, tv, 1'b0, '0, 1'b0);
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
